// ===== hw/rtl/gbu_pkg.sv =====
// shared types and constants for the gb2312 to utf-8 stream converter
package gbu_pkg;

   typedef enum logic {
      ActConvert = 1'b0,
      ActWrite   = 1'b1
   } action_type;

   typedef logic [7:0]  byte_type;
   typedef logic [13:0] flat_addr_type;
   typedef logic [15:0] code_type;
   typedef logic [6:0]  row_type;

   localparam int      TableCols = 128;
   localparam byte_type LeadBase = 8'hA0;

endpackage

// ===== hw/rtl/gbu_ifs.sv =====
// request and response channel interfaces
interface gbu_req_if;
   logic                   valid;
   logic                   ready;
   gbu_pkg::action_type    action;
   gbu_pkg::byte_type      in_byte;
   gbu_pkg::flat_addr_type entry_address;
   gbu_pkg::code_type      entry_code;

   modport source (output valid, action, in_byte, entry_address, entry_code, input ready);
   modport sink (input valid, action, in_byte, entry_address, entry_code, output ready);
endinterface

interface gbu_rsp_if;
   logic              valid;
   logic              ready;
   gbu_pkg::byte_type out_byte;
   logic              last_of_char;

   modport source (output valid, out_byte, last_of_char, input ready);
   modport sink (input valid, out_byte, last_of_char, output ready);
endinterface

// ===== hw/rtl/gbu_front.sv =====
// front end: byte pairing, code table and code point lookup
module gbu_front #(
   parameter int TABLE_ROWS = 128
) (
   input  logic              clock,
   input  logic              reset,
   gbu_req_if.sink           req_chan,
   output logic              push_valid,
   input  logic              push_ready,
   output gbu_pkg::code_type push_code
);

   localparam int TableDepth = TABLE_ROWS * gbu_pkg::TableCols;
   localparam int AddrWidth  = $clog2(TableDepth);

   gbu_pkg::code_type code_table_ff [TableDepth];
   gbu_pkg::code_type rd_code_ff;

   logic              lead_pending_ff, lead_pending_in;
   gbu_pkg::row_type  lead_row_ff, lead_row_in;
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_from_table_ff, s1_from_table_in;
   gbu_pkg::byte_type s1_byte_ff, s1_byte_in;

   logic                   accept;
   logic                   is_convert;
   logic                   is_lead;
   logic                   load_s1;
   gbu_pkg::flat_addr_type pair_addr;
   logic                   pair_in_range;
   logic                   wr_in_range;
   logic                   mem_we;
   logic                   mem_re;

   assign req_chan.ready = !s1_valid_ff || push_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_convert     = (req_chan.action == gbu_pkg::ActConvert);
   assign is_lead        = (req_chan.in_byte > gbu_pkg::LeadBase);

   assign pair_addr = {lead_row_ff, 7'b0} + {6'b0, req_chan.in_byte}
                    - {6'b0, gbu_pkg::LeadBase};
   assign pair_in_range = ({1'b0, pair_addr} < 15'(TableDepth));
   assign wr_in_range   = ({1'b0, req_chan.entry_address} < 15'(TableDepth));

   assign mem_we  = accept && !is_convert && wr_in_range;
   assign mem_re  = accept && is_convert && lead_pending_ff && pair_in_range;
   assign load_s1 = accept && is_convert && (lead_pending_ff || !is_lead);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         code_table_ff[req_chan.entry_address[AddrWidth-1:0]] <= req_chan.entry_code;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_code_ff <= code_table_ff[pair_addr[AddrWidth-1:0]];
      end
   end

   always_comb begin
      lead_pending_in  = lead_pending_ff;
      lead_row_in      = lead_row_ff;
      s1_valid_in      = s1_valid_ff;
      s1_from_table_in = s1_from_table_ff;
      s1_byte_in       = s1_byte_ff;
      if (s1_valid_ff && push_ready) begin
         s1_valid_in = 1'b0;
      end
      if (accept && is_convert) begin
         if (lead_pending_ff) begin
            lead_pending_in = 1'b0;
         end else if (is_lead) begin
            lead_pending_in = 1'b1;
            lead_row_in     = 7'(req_chan.in_byte - gbu_pkg::LeadBase);
         end
      end
      if (load_s1) begin
         s1_valid_in      = 1'b1;
         s1_from_table_in = lead_pending_ff && pair_in_range;
         s1_byte_in       = lead_pending_ff ? 8'h00 : req_chan.in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pending_ff <= 1'b0;
         lead_row_ff     <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         lead_pending_ff <= lead_pending_in;
         lead_row_ff     <= lead_row_in;
         s1_valid_ff     <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_from_table_ff <= s1_from_table_in;
      s1_byte_ff       <= s1_byte_in;
   end

   assign push_valid = s1_valid_ff;
   assign push_code  = s1_from_table_ff ? rd_code_ff : {8'h00, s1_byte_ff};

endmodule

// ===== hw/rtl/gbu_code_fifo.sv =====
// two-entry code point queue between front and back end
module gbu_code_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  gbu_pkg::code_type push_code,
   output logic              pop_valid,
   input  logic              pop_ready,
   output gbu_pkg::code_type pop_code
);

   localparam int Depth    = 2;
   localparam int PtrWidth = $clog2(Depth);
   localparam int CntWidth = $clog2(Depth + 1);

   gbu_pkg::code_type     slot_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != CntWidth'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_code   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_code;
      end
   end

endmodule

// ===== hw/rtl/gbu_back.sv =====
// back end: utf-8 serialiser with output register
module gbu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  gbu_pkg::code_type pop_code,
   gbu_rsp_if.source         rsp_chan
);

   logic              active_ff, active_in;
   gbu_pkg::code_type code_ff, code_in;
   logic [1:0]        idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   gbu_pkg::byte_type out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   logic              out_free;
   logic              emit;
   logic              done;
   logic [1:0]        seq_len;
   gbu_pkg::byte_type cur_byte;
   logic              cur_last;

   always_comb begin
      if (code_ff <= 16'h007F) begin
         seq_len = 2'd1;
      end else if (code_ff <= 16'h07FF) begin
         seq_len = 2'd2;
      end else begin
         seq_len = 2'd3;
      end
   end

   always_comb begin
      cur_byte = {2'b10, code_ff[5:0]};
      cur_last = 1'b1;
      case (seq_len)
         2'd1: begin
            cur_byte = code_ff[7:0];
            cur_last = 1'b1;
         end
         2'd2: begin
            if (idx_ff == 2'd0) begin
               cur_byte = {3'b110, code_ff[10:6]};
               cur_last = 1'b0;
            end
         end
         2'd3: begin
            if (idx_ff == 2'd0) begin
               cur_byte = {4'b1110, code_ff[15:12]};
               cur_last = 1'b0;
            end else if (idx_ff == 2'd1) begin
               cur_byte = {2'b10, code_ff[11:6]};
               cur_last = 1'b0;
            end
         end
         default: begin
            cur_byte = code_ff[7:0];
            cur_last = 1'b1;
         end
      endcase
   end

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign emit      = active_ff && out_free;
   assign done      = emit && cur_last;
   assign pop_ready = !active_ff || done;

   always_comb begin
      active_in    = active_ff;
      code_in      = code_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = cur_last;
         idx_in       = idx_ff + 1'b1;
      end
      if (done) begin
         active_in = 1'b0;
      end
      if (pop_valid && pop_ready) begin
         active_in = 1'b1;
         code_in   = pop_code;
         idx_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.out_byte     = out_byte_ff;
   assign rsp_chan.last_of_char = out_last_ff;

endmodule

// ===== hw/rtl/gb2312_to_utf8_stream.sv =====
// top level of the gb2312 to utf-8 stream converter
// each code point goes via the front stage, the queue, the code and output registers
// throughput: one word per cycle if the output is ready; a character is 1 to 3 words
// a table write or lead byte yields no word
// the code table is one single-port-write, registered-read memory in the front end
// synchronous reset clears the lead byte, queue and output; the table is not cleared
module gb2312_to_utf8_stream #(
   parameter int TABLE_ROWS = 128
) (
   input  logic      clock,
   input  logic      reset,
   gbu_req_if.sink   req_chan,
   gbu_rsp_if.source rsp_chan
);

   logic              push_valid;
   logic              push_ready;
   gbu_pkg::code_type push_code;
   logic              pop_valid;
   logic              pop_ready;
   gbu_pkg::code_type pop_code;

   gbu_front #(
      .TABLE_ROWS (TABLE_ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_code  (push_code)
   );

   gbu_code_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_code  (push_code),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_code   (pop_code)
   );

   gbu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_code  (pop_code),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the gb2312 to utf-8 stream converter
module testbench;

   localparam int TableDepth = 128 * gbu_pkg::TableCols;
   localparam int QuietLimit = 2000;

   typedef struct packed {
      gbu_pkg::action_type    action;
      gbu_pkg::byte_type      in_byte;
      gbu_pkg::flat_addr_type entry_address;
      gbu_pkg::code_type      entry_code;
   } gb_item_type;

   typedef struct packed {
      gbu_pkg::byte_type out_byte;
      logic              last_of_char;
   } utf8_word_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   gb_item_type   req_drv = '0;
   logic          rsp_ready = 1'b0;

   gb_item_type   gb_stream_q [$];
   utf8_word_type utf8_due [$];
   bit            loaded [TableDepth];

   gbu_pkg::code_type code_mirror [TableDepth];
   logic              lead_held = 1'b0;
   gbu_pkg::row_type  lead_row = '0;

   int         total_items = 0;
   int         accepted_items = 0;
   int         quiet_cycles = 0;
   int         failures = 0;

   gbu_req_if req_if ();
   gbu_rsp_if rsp_if ();

   assign req_if.valid         = req_valid;
   assign req_if.action        = req_drv.action;
   assign req_if.in_byte       = req_drv.in_byte;
   assign req_if.entry_address = req_drv.entry_address;
   assign req_if.entry_code    = req_drv.entry_code;
   assign rsp_if.ready         = rsp_ready;

   gb2312_to_utf8_stream dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #10 clock = ~clock;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // idle percentage for the current phase of the run
   function automatic int idle_pct(bit sender);
      int phase;
      phase = (total_items == 0) ? 0 : accepted_items * 4 / total_items;
      case (phase)
         0: return 0;
         1: return sender ? 50 : 0;
         2: return sender ? 0 : 50;
         default: return 30;
      endcase
   endfunction

   function automatic gbu_pkg::code_type random_code();
      gbu_pkg::code_type corners [6];
      corners = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
      case ($urandom_range(3))
         0: return gbu_pkg::code_type'($urandom_range(16'h007F));
         1: return gbu_pkg::code_type'($urandom_range(16'h07FF, 16'h0080));
         2: return gbu_pkg::code_type'($urandom_range(16'hFFFF, 16'h0800));
         default: return corners[$urandom_range(5)];
      endcase
   endfunction

   function automatic void queue_write(gbu_pkg::flat_addr_type addr, gbu_pkg::code_type code);
      gb_item_type item;
      item.action        = gbu_pkg::ActWrite;
      item.in_byte       = gbu_pkg::byte_type'($urandom_range(255));
      item.entry_address = addr;
      item.entry_code    = code;
      gb_stream_q.push_back(item);
      loaded[addr] = 1'b1;
   endfunction

   function automatic void queue_byte(gbu_pkg::byte_type b);
      gb_item_type item;
      item.action        = gbu_pkg::ActConvert;
      item.in_byte       = b;
      item.entry_address = gbu_pkg::flat_addr_type'($urandom_range(16383));
      item.entry_code    = gbu_pkg::code_type'($urandom_range(16'hFFFF));
      gb_stream_q.push_back(item);
   endfunction

   function automatic void queue_utf8(gbu_pkg::code_type cp);
      if (cp <= 16'h007F) begin
         utf8_due.push_back({cp[7:0], 1'b1});
      end else if (cp <= 16'h07FF) begin
         utf8_due.push_back({3'b110, cp[10:6], 1'b0});
         utf8_due.push_back({2'b10, cp[5:0], 1'b1});
      end else begin
         utf8_due.push_back({4'b1110, cp[15:12], 1'b0});
         utf8_due.push_back({2'b10, cp[11:6], 1'b0});
         utf8_due.push_back({2'b10, cp[5:0], 1'b1});
      end
   endfunction

   function automatic void transcode(gb_item_type item);
      gbu_pkg::flat_addr_type addr;
      if (item.action == gbu_pkg::ActWrite) begin
         code_mirror[item.entry_address] = item.entry_code;
      end else if (lead_held) begin
         addr = gbu_pkg::flat_addr_type'(int'(lead_row) * gbu_pkg::TableCols
                                         + int'(item.in_byte) - int'(gbu_pkg::LeadBase));
         lead_held = 1'b0;
         queue_utf8(code_mirror[addr]);
      end else if (item.in_byte > gbu_pkg::LeadBase) begin
         lead_held = 1'b1;
         lead_row  = gbu_pkg::row_type'(item.in_byte - gbu_pkg::LeadBase);
      end else begin
         queue_utf8(gbu_pkg::code_type'(item.in_byte));
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_if.ready) begin
            transcode(req_drv);
            accepted_items <= accepted_items + 1;
         end
         if (!req_valid || req_if.ready) begin
            if (gb_stream_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
               req_drv   <= gb_stream_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      utf8_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_ready) begin
            if (utf8_due.size() == 0) begin
               $error("unexpected word: out_byte %h last_of_char %b",
                      rsp_if.out_byte, rsp_if.last_of_char);
               failures++;
            end else begin
               want = utf8_due.pop_front();
               if (rsp_if.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, actual %h", want.out_byte, rsp_if.out_byte);
                  failures++;
               end
               if (rsp_if.last_of_char !== want.last_of_char) begin
                  $error("last_of_char: expected %b, actual %b",
                         want.last_of_char, rsp_if.last_of_char);
                  failures++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= idle_pct(1'b0));
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_if.ready) || (rsp_if.valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QuietLimit) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int                     lead;
      int                     second;
      gbu_pkg::flat_addr_type addr;

      // table corners and every encoding length
      queue_write(14'd0, 16'h0000);
      queue_write(14'd16383, 16'hFFFF);
      queue_write(14'd129, 16'h007F);
      queue_write(14'd12255, 16'h0080);
      queue_write(14'd12000, 16'h07FF);
      queue_write(14'd16352, 16'h0800);
      queue_byte(8'h00);
      queue_byte(8'h7F);
      queue_byte(8'h80);
      queue_byte(8'hA0);
      queue_byte(8'hA1);
      queue_byte(8'h20);
      queue_byte(8'hA1);
      queue_byte(8'h1F);
      // write while a lead byte is held
      queue_byte(8'hA1);
      queue_write(14'd129, 16'h0123);
      queue_byte(8'hA1);
      queue_byte(8'hFF);
      queue_byte(8'hFF);
      // second bytes below the lead base reach back into earlier rows, and past address 0 wrap to the top of the table
      queue_byte(8'hFF);
      queue_byte(8'h00);
      queue_byte(8'hA1);
      queue_byte(8'h00);

      while (gb_stream_q.size() < 220) begin
         case ($urandom_range(9))
            0, 1: queue_write(gbu_pkg::flat_addr_type'($urandom_range(16383)), random_code());
            2, 3: queue_byte(gbu_pkg::byte_type'($urandom_range(int'(gbu_pkg::LeadBase))));
            default: begin
               lead   = $urandom_range(8'hFF, 8'hA1);
               second = $urandom_range(255);
               addr   = gbu_pkg::flat_addr_type'((lead - int'(gbu_pkg::LeadBase))
                                                 * gbu_pkg::TableCols + second
                                                 - int'(gbu_pkg::LeadBase));
               if (!loaded[addr] || $urandom_range(3) == 0) begin
                  queue_write(addr, random_code());
               end
               queue_byte(gbu_pkg::byte_type'(lead));
               if ($urandom_range(4) == 0) begin
                  queue_write(gbu_pkg::flat_addr_type'($urandom_range(16383)), random_code());
               end
               queue_byte(gbu_pkg::byte_type'(second));
            end
         endcase
      end
      total_items = gb_stream_q.size();

      while (reset || gb_stream_q.size() != 0 || req_valid || utf8_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      if (failures == 0 && utf8_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/gbu_pkg.sv
hw/rtl/gbu_ifs.sv
hw/rtl/gbu_front.sv
hw/rtl/gbu_code_fifo.sv
hw/rtl/gbu_back.sv
hw/rtl/gb2312_to_utf8_stream.sv
sim/testbench.sv
